// ===== design/x86agu_pkg.sv =====
// ----------------------------------------------------------------------------
// x86agu_pkg
// Shared types and codes for the x86 operand address generation unit.
// ----------------------------------------------------------------------------
package x86agu_pkg;

  localparam int NUM_GPR = 8;
  localparam int NUM_SEG = 6;

  localparam logic [2:0] SEG_ES = 3'd0;
  localparam logic [2:0] SEG_SS = 3'd2;
  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_SP = 3'd4;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;

  // operand routines
  typedef enum logic [5:0] {
    K_IMM        = 6'd0,  K_REG8       = 6'd1,  K_REG16      = 6'd2,
    K_REG32      = 6'd3,  K_BASE8      = 6'd4,  K_BASE16     = 6'd5,
    K_BASE32     = 6'd6,  K_SEGREG     = 6'd7,  K_SEGUPD     = 6'd8,
    K_MODRM16    = 6'd9,  K_FAR16      = 6'd10, K_LEA16      = 6'd11,
    K_BOUND16    = 6'd12, K_PUSH_SP    = 6'd13, K_POP_SP     = 6'd14,
    K_PUSHA_SP   = 6'd15, K_POPA_SP    = 6'd16, K_STR_SI     = 6'd17,
    K_STR_DI     = 6'd18, K_MODRM32    = 6'd19, K_FAR32      = 6'd20,
    K_SIB        = 6'd21, K_FAR_SIB    = 6'd22, K_LEA32      = 6'd23,
    K_BOUND32    = 6'd24, K_LEA_SIB    = 6'd25, K_BOUND_SIB  = 6'd26,
    K_PUSH_ESP   = 6'd27, K_POP_ESP    = 6'd28, K_PUSHA_ESP  = 6'd29,
    K_POPA_ESP   = 6'd30, K_STR_ESI    = 6'd31, K_STR_EDI    = 6'd32,
    K_CALL_FAR   = 6'd33, K_IRET       = 6'd34, K_RET_FAR    = 6'd35,
    K_XLAT       = 6'd36, K_WR_GPR     = 6'd37, K_WR_SEG     = 6'd38
  } kind_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [3:0]  reg_sel;
    logic [3:0]  base_sel;
    logic [3:0]  index_sel;
    logic [1:0]  scale_shift;
    logic [31:0] displacement;
    logic [2:0]  op_size;
    logic [2:0]  segment_sel;
    logic [2:0]  cond_segment;
    logic        stack_is_16;
    logic        addr_is_16;
    logic [31:0] data_value;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] offset;
    logic [31:0] offset_second;
    logic [2:0]  segment_out;
    logic [5:0]  access_size;
    logic [1:0]  mem_count;
  } res_t;

  // register file write request
  typedef struct packed {
    logic        gpr_we;
    logic        seg_we;
    logic [3:0]  sel;
    logic [2:0]  size;
    logic [31:0] data;
  } wr_t;

  typedef logic [NUM_GPR-1:0][31:0] gpr_arr_t;
  typedef logic [NUM_SEG-1:0][15:0] seg_arr_t;

endpackage

// ===== design/x86_operand_address_generation.sv =====
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while the output is not stalled;
// the register file is read and written in the stage between the two
// registers, so a write is seen by the very next item. Reset (rst_n low,
// synchronous) clears all general and segment registers and both valid flags.
// ----------------------------------------------------------------------------
// x86_operand_address_generation
// Register file and operand/address former for x86 operand reads.
// ----------------------------------------------------------------------------
module x86_operand_address_generation (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, low bit up: reg_sel[3:0], base_sel[7:4], index_sel[11:8],
  // scale_shift[13:12], displacement[45:14], op_size[48:46],
  // segment_sel[51:49], cond_segment[54:52], stack_is_16[55],
  // addr_is_16[56], data_value[88:57], zero pad[95:89]
  input  logic [95:0]  in_tdata,
  input  logic [5:0]   in_tuser,   // kind[5:0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata, low bit up: value[31:0], offset[63:32], offset_second[95:64],
  // segment_out[98:96], access_size[104:99], zero pad[111:105]
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser   // mem_count[1:0]
);
  import x86agu_pkg::*;

  item_t    item_in, item_r;
  logic     s1_valid_r;
  res_t     res_nxt, res_r;
  logic     out_valid_r;
  logic     adv;
  wr_t      wr;
  gpr_arr_t gpr;
  seg_arr_t seg;

  // unpack the incoming transaction
  always_comb begin
    item_in.kind         = in_tuser;
    item_in.reg_sel      = in_tdata[3:0];
    item_in.base_sel     = in_tdata[7:4];
    item_in.index_sel    = in_tdata[11:8];
    item_in.scale_shift  = in_tdata[13:12];
    item_in.displacement = in_tdata[45:14];
    item_in.op_size      = in_tdata[48:46];
    item_in.segment_sel  = in_tdata[51:49];
    item_in.cond_segment = in_tdata[54:52];
    item_in.stack_is_16  = in_tdata[55];
    item_in.addr_is_16   = in_tdata[56];
    item_in.data_value   = in_tdata[88:57];
  end

  // item in the input register moves on when the result register is free
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  // register writes commit as their item leaves the input register
  always_comb begin
    wr.gpr_we = adv && (item_r.kind == K_WR_GPR);
    wr.seg_we = adv && (item_r.kind == K_WR_SEG);
    wr.sel    = item_r.reg_sel;
    wr.size   = item_r.op_size;
    wr.data   = item_r.data_value;
  end

  x86agu_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .gpr   (gpr),
    .seg   (seg)
  );

  x86agu_calc u_calc (
    .item (item_r),
    .gpr  (gpr),
    .seg  (seg),
    .res  (res_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_in;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.access_size, res_r.segment_out,
                       res_r.offset_second, res_r.offset, res_r.value};
  assign out_tuser  = res_r.mem_count;

endmodule

// ===== design/x86agu_regs.sv =====
// ----------------------------------------------------------------------------
// x86agu_regs
// General and segment register storage with byte/word merge on write.
// ----------------------------------------------------------------------------
module x86agu_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  x86agu_pkg::wr_t      wr,
  output x86agu_pkg::gpr_arr_t gpr,
  output x86agu_pkg::seg_arr_t seg
);
  import x86agu_pkg::*;

  gpr_arr_t gpr_r, gpr_nxt;
  seg_arr_t seg_r, seg_nxt;

  always_comb begin
    gpr_nxt = gpr_r;
    seg_nxt = seg_r;
    if (wr.gpr_we && !wr.sel[3]) begin
      if (wr.size == 3'd1) begin
        // 8-bit views: 4..7 are the high bytes of 0..3
        if (wr.sel[2]) begin
          gpr_nxt[{1'b0, wr.sel[1:0]}][15:8] = wr.data[7:0];
        end else begin
          gpr_nxt[{1'b0, wr.sel[1:0]}][7:0] = wr.data[7:0];
        end
      end else if (wr.size == 3'd2) begin
        gpr_nxt[wr.sel[2:0]][15:0] = wr.data[15:0];
      end else begin
        gpr_nxt[wr.sel[2:0]] = wr.data;
      end
    end
    if (wr.seg_we && wr.sel < 4'(NUM_SEG)) begin
      seg_nxt[wr.sel[2:0]] = wr.data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_r <= '0;
      seg_r <= '0;
    end else begin
      gpr_r <= gpr_nxt;
      seg_r <= seg_nxt;
    end
  end

  assign gpr = gpr_r;
  assign seg = seg_r;

endmodule

// ===== design/x86agu_calc.sv =====
// ----------------------------------------------------------------------------
// x86agu_calc
// Operand value and memory offset formation for one item.
// ----------------------------------------------------------------------------
module x86agu_calc (
  input  x86agu_pkg::item_t    item,
  input  x86agu_pkg::gpr_arr_t gpr,
  input  x86agu_pkg::seg_arr_t seg,
  output x86agu_pkg::res_t     res
);
  import x86agu_pkg::*;

  function automatic logic [31:0] rd32(input gpr_arr_t g, input logic [3:0] s);
    return s[3] ? 32'd0 : g[s[2:0]];
  endfunction

  function automatic logic [31:0] rd16(input gpr_arr_t g, input logic [3:0] s);
    return s[3] ? 32'd0 : {16'd0, g[s[2:0]][15:0]};
  endfunction

  function automatic logic [31:0] rd8(input gpr_arr_t g, input logic [3:0] s);
    logic [31:0] r;
    r = '0;
    if (!s[3]) begin
      r[7:0] = s[2] ? g[{1'b0, s[1:0]}][15:8] : g[{1'b0, s[1:0]}][7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] rdseg(input seg_arr_t sg, input logic [3:0] s);
    return (s < 4'(NUM_SEG)) ? {16'd0, sg[s[2:0]]} : 32'd0;
  endfunction

  logic [31:0] base32, index32, disp;
  logic [15:0] ea16;
  logic [31:0] ea32, eas, esp, size32;
  logic [15:0] sp, size16;
  logic [5:0]  size6;
  logic [15:0] stk16_ofs;
  logic [31:0] stk32_ofs;
  logic [31:0] xlat_ofs;

  always_comb begin
    base32  = rd32(gpr, item.base_sel);
    index32 = rd32(gpr, item.index_sel);
    disp    = item.displacement;
    size32  = {29'd0, item.op_size};
    size16  = {13'd0, item.op_size};
    size6   = {3'd0, item.op_size};
    ea16    = base32[15:0] + index32[15:0] + disp[15:0];
    ea32    = base32 + index32 + disp;
    eas     = base32 + (index32 << item.scale_shift) + disp;
    esp     = gpr[REG_SP];
    sp      = esp[15:0];

    // far control transfers: 16- or 32-bit stack pointer arithmetic
    unique case (kind_t'(item.kind))
      K_CALL_FAR: begin
        stk16_ofs = sp - (size16 << 1);
        stk32_ofs = esp - (size32 << 1);
      end
      K_IRET: begin
        stk16_ofs = sp + (size16 << 1);
        stk32_ofs = esp + (size32 << 1);
      end
      default: begin
        stk16_ofs = sp + size16;
        stk32_ofs = esp + size32;
      end
    endcase

    xlat_ofs = item.addr_is_16
             ? {16'd0, gpr[REG_BX][15:0] + {8'd0, gpr[0][7:0]}}
             : gpr[REG_BX] + {24'd0, gpr[0][7:0]};

    res = '0;
    unique case (kind_t'(item.kind))
      K_IMM:    res.value = item.data_value;
      K_REG8:   res.value = rd8(gpr, item.reg_sel);
      K_REG16:  res.value = rd16(gpr, item.reg_sel);
      K_REG32:  res.value = rd32(gpr, item.reg_sel);
      K_BASE8:  res.value = rd8(gpr, item.base_sel);
      K_BASE16: res.value = rd16(gpr, item.base_sel);
      K_BASE32: res.value = base32;
      K_SEGREG: res.value = rdseg(seg, item.reg_sel);
      K_SEGUPD: res.value = rdseg(seg, {1'b0, item.cond_segment});
      K_MODRM16, K_FAR16: begin
        res.offset      = {16'd0, ea16};
        res.segment_out = item.segment_sel;
        res.access_size = (item.kind == K_FAR16) ? size6 + 6'd2 : size6;
        res.mem_count   = 2'd1;
      end
      K_LEA16: res.value = {16'd0, ea16};
      K_BOUND16: begin
        res.offset        = {16'd0, ea16};
        res.offset_second = {16'd0, ea16 + size16};
        res.segment_out   = item.segment_sel;
        res.access_size   = size6;
        res.mem_count     = 2'd2;
      end
      K_PUSH_SP, K_POP_SP: begin
        res.offset      = {16'd0, (item.kind == K_PUSH_SP) ? sp - size16 : sp};
        res.segment_out = SEG_SS;
        res.access_size = size6;
        res.mem_count   = 2'd1;
      end
      K_PUSHA_SP, K_POPA_SP: begin
        res.offset      = {16'd0, (item.kind == K_PUSHA_SP) ? sp - (size16 << 3) : sp};
        res.segment_out = SEG_SS;
        res.access_size = size6 << 3;
        res.mem_count   = 2'd1;
      end
      K_STR_SI, K_STR_ESI: begin
        res.offset      = (item.kind == K_STR_SI) ? {16'd0, gpr[REG_SI][15:0]}
                                                  : gpr[REG_SI];
        res.segment_out = item.segment_sel;
        res.access_size = size6;
        res.mem_count   = 2'd1;
      end
      K_STR_DI, K_STR_EDI: begin
        res.offset      = (item.kind == K_STR_DI) ? {16'd0, gpr[REG_DI][15:0]}
                                                  : gpr[REG_DI];
        res.segment_out = SEG_ES;
        res.access_size = size6;
        res.mem_count   = 2'd1;
      end
      K_MODRM32, K_FAR32: begin
        res.offset      = ea32;
        res.segment_out = item.segment_sel;
        res.access_size = (item.kind == K_FAR32) ? size6 + 6'd2 : size6;
        res.mem_count   = 2'd1;
      end
      K_SIB, K_FAR_SIB: begin
        res.offset      = eas;
        res.segment_out = item.segment_sel;
        res.access_size = (item.kind == K_FAR_SIB) ? size6 + 6'd2 : size6;
        res.mem_count   = 2'd1;
      end
      K_LEA32:   res.value = ea32;
      K_LEA_SIB: res.value = eas;
      K_BOUND32, K_BOUND_SIB: begin
        res.offset        = (item.kind == K_BOUND32) ? ea32 : eas;
        res.offset_second = ((item.kind == K_BOUND32) ? ea32 : eas) + size32;
        res.segment_out   = item.segment_sel;
        res.access_size   = size6;
        res.mem_count     = 2'd2;
      end
      K_PUSH_ESP, K_POP_ESP: begin
        res.offset      = (item.kind == K_PUSH_ESP) ? esp - size32 : esp;
        res.segment_out = SEG_SS;
        res.access_size = size6;
        res.mem_count   = 2'd1;
      end
      K_PUSHA_ESP, K_POPA_ESP: begin
        res.offset      = (item.kind == K_PUSHA_ESP) ? esp - (size32 << 3) : esp;
        res.segment_out = SEG_SS;
        res.access_size = size6 << 3;
        res.mem_count   = 2'd1;
      end
      K_CALL_FAR, K_IRET, K_RET_FAR: begin
        res.offset      = item.stack_is_16 ? {16'd0, stk16_ofs} : stk32_ofs;
        res.segment_out = SEG_SS;
        res.access_size = size6;
        res.mem_count   = 2'd1;
      end
      K_XLAT: begin
        res.offset      = xlat_ofs;
        res.segment_out = item.segment_sel;
        res.access_size = 6'd1;
        res.mem_count   = 2'd1;
      end
      default: res = '0;
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the x86 operand address generation unit.
// The bench keeps its own copy of the general and segment registers and works
// out the expected result of every accepted input transaction. A scoreboard
// compares each result transaction with the oldest expected one, field by
// field. The directed items come first, then weighted random traffic, with
// random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import x86agu_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow register file, address forming and result checking
  // --------------------------------------------------------------------------
  class agu_scoreboard;
    logic [31:0] gpr_shadow [NUM_GPR];
    logic [15:0] seg_shadow [NUM_SEG];
    res_t        expected_q [$];
    int          mismatches;

    function new();
      foreach (gpr_shadow[i]) gpr_shadow[i] = '0;
      foreach (seg_shadow[i]) seg_shadow[i] = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // register numbers of 8 and above read as zero in every view
    function logic [31:0] gpr32(logic [3:0] sel);
      return (sel < NUM_GPR) ? gpr_shadow[sel[2:0]] : 32'd0;
    endfunction

    function logic [31:0] gpr8(logic [3:0] sel);
      if (sel >= NUM_GPR) return 32'd0;
      if (sel < 4) return {24'd0, gpr_shadow[{1'b0, sel[1:0]}][7:0]};
      return {24'd0, gpr_shadow[{1'b0, sel[1:0]}][15:8]};    // AH..BH
    endfunction

    function logic [31:0] seg_value(logic [3:0] sel);
      return (sel < NUM_SEG) ? {16'd0, seg_shadow[sel[2:0]]} : 32'd0;
    endfunction

    function logic [31:0] wrap16(logic [31:0] x);
      return {16'd0, x[15:0]};
    endfunction

    function res_t access(logic [31:0] ofs, logic [31:0] ofs2, logic [2:0] seg,
                          logic [31:0] size, logic [1:0] count);
      res_t r;
      r               = '0;
      r.offset        = ofs;
      r.offset_second = ofs2;
      r.segment_out   = seg;
      r.access_size   = size[5:0];
      r.mem_count     = count;
      return r;
    endfunction

    // Work out the result of one accepted transaction and apply any write.
    function void note_input(item_t it);
      res_t        r;
      logic [31:0] base32, index32, ea16, ea32, eas, esp, sp, sz, t;
      base32  = gpr32(it.base_sel);
      index32 = gpr32(it.index_sel);
      ea32    = base32 + index32 + it.displacement;
      ea16    = wrap16(ea32);                 // low half of the sum is the 16-bit sum
      eas     = base32 + (index32 << it.scale_shift) + it.displacement;
      esp     = gpr_shadow[REG_SP];
      sp      = wrap16(esp);
      sz      = 32'(it.op_size);
      r       = '0;
      case (it.kind)
        K_IMM:       r.value = it.data_value;
        K_REG8:      r.value = gpr8(it.reg_sel);
        K_REG16:     r.value = wrap16(gpr32(it.reg_sel));
        K_REG32:     r.value = gpr32(it.reg_sel);
        K_BASE8:     r.value = gpr8(it.base_sel);
        K_BASE16:    r.value = wrap16(gpr32(it.base_sel));
        K_BASE32:    r.value = gpr32(it.base_sel);
        K_SEGREG:    r.value = seg_value(it.reg_sel);
        K_SEGUPD:    r.value = seg_value({1'b0, it.cond_segment});
        K_MODRM16:   r = access(ea16, 32'd0, it.segment_sel, sz, 2'd1);
        K_FAR16:     r = access(ea16, 32'd0, it.segment_sel, sz + 32'd2, 2'd1);
        K_LEA16:     r.value = ea16;
        K_BOUND16:   r = access(ea16, wrap16(ea16 + sz), it.segment_sel, sz, 2'd2);
        K_PUSH_SP:   r = access(wrap16(sp - sz), 32'd0, SEG_SS, sz, 2'd1);
        K_POP_SP:    r = access(sp, 32'd0, SEG_SS, sz, 2'd1);
        K_PUSHA_SP:  r = access(wrap16(sp - (sz << 3)), 32'd0, SEG_SS, sz << 3, 2'd1);
        K_POPA_SP:   r = access(sp, 32'd0, SEG_SS, sz << 3, 2'd1);
        K_STR_SI:    r = access(wrap16(gpr_shadow[REG_SI]), 32'd0, it.segment_sel, sz, 2'd1);
        K_STR_DI:    r = access(wrap16(gpr_shadow[REG_DI]), 32'd0, SEG_ES, sz, 2'd1);
        K_MODRM32:   r = access(ea32, 32'd0, it.segment_sel, sz, 2'd1);
        K_FAR32:     r = access(ea32, 32'd0, it.segment_sel, sz + 32'd2, 2'd1);
        K_SIB:       r = access(eas, 32'd0, it.segment_sel, sz, 2'd1);
        K_FAR_SIB:   r = access(eas, 32'd0, it.segment_sel, sz + 32'd2, 2'd1);
        K_LEA32:     r.value = ea32;
        K_BOUND32:   r = access(ea32, ea32 + sz, it.segment_sel, sz, 2'd2);
        K_LEA_SIB:   r.value = eas;
        K_BOUND_SIB: r = access(eas, eas + sz, it.segment_sel, sz, 2'd2);
        K_PUSH_ESP:  r = access(esp - sz, 32'd0, SEG_SS, sz, 2'd1);
        K_POP_ESP:   r = access(esp, 32'd0, SEG_SS, sz, 2'd1);
        K_PUSHA_ESP: r = access(esp - (sz << 3), 32'd0, SEG_SS, sz << 3, 2'd1);
        K_POPA_ESP:  r = access(esp, 32'd0, SEG_SS, sz << 3, 2'd1);
        K_STR_ESI:   r = access(gpr_shadow[REG_SI], 32'd0, it.segment_sel, sz, 2'd1);
        K_STR_EDI:   r = access(gpr_shadow[REG_DI], 32'd0, SEG_ES, sz, 2'd1);
        K_CALL_FAR: begin
          t = it.stack_is_16 ? wrap16(sp - (sz << 1)) : esp - (sz << 1);
          r = access(t, 32'd0, SEG_SS, sz, 2'd1);
        end
        K_IRET: begin
          t = it.stack_is_16 ? wrap16(sp + (sz << 1)) : esp + (sz << 1);
          r = access(t, 32'd0, SEG_SS, sz, 2'd1);
        end
        K_RET_FAR: begin
          t = it.stack_is_16 ? wrap16(sp + sz) : esp + sz;
          r = access(t, 32'd0, SEG_SS, sz, 2'd1);
        end
        K_XLAT: begin
          t = gpr_shadow[REG_BX] + gpr8(4'd0);
          r = access(it.addr_is_16 ? wrap16(t) : t, 32'd0, it.segment_sel, 32'd1, 2'd1);
        end
        K_WR_GPR: begin
          if (it.reg_sel < NUM_GPR) begin
            if (it.op_size == 3'd1) begin
              if (it.reg_sel < 4) begin
                gpr_shadow[{1'b0, it.reg_sel[1:0]}][7:0] = it.data_value[7:0];
              end else begin
                gpr_shadow[{1'b0, it.reg_sel[1:0]}][15:8] = it.data_value[7:0];
              end
            end else if (it.op_size == 3'd2) begin
              gpr_shadow[it.reg_sel[2:0]][15:0] = it.data_value[15:0];
            end else begin
              gpr_shadow[it.reg_sel[2:0]] = it.data_value;
            end
          end
        end
        K_WR_SEG: begin
          if (it.reg_sel < NUM_SEG) seg_shadow[it.reg_sel[2:0]] = it.data_value[15:0];
        end
        default: ;   // unknown kinds: all-zero result, no state change
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result transaction with nothing outstanding: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value)
        report($sformatf("value %h, want %h", got.value, want.value));
      if (got.offset !== want.offset)
        report($sformatf("offset %h, want %h", got.offset, want.offset));
      if (got.offset_second !== want.offset_second)
        report($sformatf("offset_second %h, want %h", got.offset_second, want.offset_second));
      if (got.segment_out !== want.segment_out)
        report($sformatf("segment_out %0d, want %0d", got.segment_out, want.segment_out));
      if (got.access_size !== want.access_size)
        report($sformatf("access_size %0d, want %0d", got.access_size, want.access_size));
      if (got.mem_count !== want.mem_count)
        report($sformatf("mem_count %0d, want %0d", got.mem_count, want.mem_count));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata   = '0;     // reg_sel, base_sel, index_sel, ... data_value
  logic [5:0]   in_tuser   = '0;     // kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;           // value, offset, offset_second, segment_out, access_size
  logic [1:0]   out_tuser;           // mem_count

  bit            steady = 1'b0;      // set: neither side idles
  int            stall_left = 0;
  agu_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  x86_operand_address_generation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Idle lengths: mostly short, the odd long one
  // --------------------------------------------------------------------------
  function int idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function int send_gap();
    if (steady || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  // --------------------------------------------------------------------------
  // Monitors. Both sample the values present at the clock edge; the bench
  // drives only with nonblocking assignments, so there is no race.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t acc;
    if (in_tvalid && in_tready) begin
      acc.kind         = in_tuser;
      acc.reg_sel      = in_tdata[3:0];
      acc.base_sel     = in_tdata[7:4];
      acc.index_sel    = in_tdata[11:8];
      acc.scale_shift  = in_tdata[13:12];
      acc.displacement = in_tdata[45:14];
      acc.op_size      = in_tdata[48:46];
      acc.segment_sel  = in_tdata[51:49];
      acc.cond_segment = in_tdata[54:52];
      acc.stack_is_16  = in_tdata[55];
      acc.addr_is_16   = in_tdata[56];
      acc.data_value   = in_tdata[88:57];
      sb.note_input(acc);
    end
  end

  // Result side: check each accepted transaction, then decide back-pressure
  // for the next cycle.
  always @(posedge clk) begin
    res_t got;
    if (out_tvalid && out_tready) begin
      got.value         = out_tdata[31:0];
      got.offset        = out_tdata[63:32];
      got.offset_second = out_tdata[95:64];
      got.segment_out   = out_tdata[98:96];
      got.access_size   = out_tdata[104:99];
      got.mem_count     = out_tuser;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // Present one transaction and hold it until accepted. in_tvalid is only
  // lowered when a gap is inserted, never lowered and raised in one step.
  task send_item(item_t it);
    int gap;
    gap = send_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {7'd0, it.data_value, it.addr_is_16, it.stack_is_16, it.cond_segment,
                  it.segment_sel, it.op_size, it.displacement, it.scale_shift,
                  it.index_sel, it.base_sel, it.reg_sel};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait for every outstanding result.
  task drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function logic [3:0] rand_sel();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(8, 15));   // no register
    return 4'($urandom_range(0, 7));
  endfunction

  // Weighted random item: plenty of register writes so that the reads see
  // varied state, mostly legal sizes and segments, some odd values.
  function item_t rand_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      it.kind = K_WR_GPR;
    else if (pick < 30) it.kind = K_WR_SEG;
    else if (pick < 97) it.kind = 6'($urandom_range(0, 36));
    else                it.kind = 6'($urandom_range(39, 63));
    it.reg_sel     = rand_sel();
    it.base_sel    = rand_sel();
    it.index_sel   = rand_sel();
    it.scale_shift = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       it.displacement = 32'($urandom_range(0, 255)) - 32'd128;
      1:       it.displacement = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       it.displacement = 32'hFFFF_FFFF;
      default: it.displacement = $urandom();
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      case ($urandom_range(0, 2))
        0:       it.op_size = 3'd1;
        1:       it.op_size = 3'd2;
        default: it.op_size = 3'd4;
      endcase
    end else begin
      it.op_size = 3'($urandom_range(0, 7));
    end
    it.segment_sel  = 3'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                      : $urandom_range(0, 7));
    it.cond_segment = 3'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                      : $urandom_range(0, 7));
    it.stack_is_16  = 1'($urandom_range(0, 1));
    it.addr_is_16   = 1'($urandom_range(0, 1));
    // small values push the stack pointer close to the wrap point
    case ($urandom_range(0, 5))
      0:       it.data_value = 32'($urandom_range(0, 40));
      1:       it.data_value = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      2:       it.data_value = 32'h0000_FFFF - 32'($urandom_range(0, 40));
      default: it.data_value = $urandom();
    endcase
    return it;
  endfunction

  // Directed part: registers to known extremes, the high-byte, 16-bit and
  // no-register write paths, bad segment numbers, then one item of every kind.
  task directed();
    item_t it;
    send_item('{kind: K_WR_GPR, reg_sel: 4'd4, op_size: 3'd4, data_value: 32'h0000_0002,
                default: '0});
    send_item('{kind: K_WR_GPR, reg_sel: 4'd3, op_size: 3'd4, data_value: 32'hFFFF_FFF0,
                default: '0});
    send_item('{kind: K_WR_GPR, reg_sel: 4'd0, op_size: 3'd4, data_value: 32'h1234_5678,
                default: '0});
    send_item('{kind: K_WR_GPR, reg_sel: 4'd7, op_size: 3'd1, data_value: 32'hFFFF_FFAB,
                default: '0});
    send_item('{kind: K_WR_GPR, reg_sel: 4'd6, op_size: 3'd2, data_value: 32'hFFFF_FFFF,
                default: '0});
    send_item('{kind: K_WR_GPR, reg_sel: 4'd8, op_size: 3'd4, data_value: 32'hDEAD_BEEF,
                default: '0});
    send_item('{kind: K_WR_SEG, reg_sel: 4'd5, data_value: 32'hFFFF_BEEF, default: '0});
    send_item('{kind: K_REG8, reg_sel: 4'd4, default: '0});
    send_item('{kind: K_SEGREG, reg_sel: 4'd5, default: '0});
    send_item('{kind: K_SEGUPD, cond_segment: 3'd6, default: '0});
    // kind sweep, unknown kind last, with the field extremes spread across it
    for (int k = 0; k <= 39; k++) begin
      it              = '0;
      it.kind         = (k == 39) ? 6'd63 : 6'(k);
      it.reg_sel      = (k % 3 == 0) ? 4'd15 : 4'(k % 8);
      it.base_sel     = 4'd3;
      it.index_sel    = (k % 4 == 0) ? 4'd8 : 4'd7;
      it.scale_shift  = 2'(k % 4);
      it.displacement = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      it.op_size      = 3'(k % 8);
      it.segment_sel  = 3'(k % 8);
      it.cond_segment = 3'(7 - k % 8);
      it.stack_is_16  = k[0];
      it.addr_is_16   = k[1];
      it.data_value   = k[2] ? 32'hFFFF_FFFF : 32'h0000_0000;
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    drain();                 // sender holds off until nothing is outstanding
    for (int chunk = 0; chunk < 7; chunk++) begin
      steady = (chunk == 2 || chunk == 5);
      repeat (200) send_item(rand_item());
      if (chunk == 3) drain();
    end
    steady = 1'b0;
    drain();
    repeat (4) @(posedge clk);   // catch any stray result transaction
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/x86agu_pkg.sv
design/x86agu_regs.sv
design/x86agu_calc.sv
design/x86_operand_address_generation.sv
verif/testbench.sv
